// File: hw/rtl/feedback_echo_delay_unit_macros.svh
// feedback_echo_delay_unit_macros.svh: assertion macros for the echo delay unit
// needs a clk_i and an active-low rst_ni in the scope where a macro is used
`ifndef FEEDBACK_ECHO_DELAY_UNIT_MACROS_SVH
`define FEEDBACK_ECHO_DELAY_UNIT_MACROS_SVH

// same-cycle implication, quiet during reset
`define FED_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, quiet during reset
`define FED_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/fed_pkg.sv
// fed_pkg: shared constants for the feedback echo delay unit
// no dependencies; used by the top level
package fed_pkg;

  // delay line geometry
  localparam int unsigned DelayDepth = 8192;
  localparam int unsigned RamAw      = $clog2(DelayDepth);

  // sample and register widths
  localparam int unsigned SampleW = 16;
  localparam int unsigned GainW   = 16;
  localparam int unsigned PosW    = 13;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgW    = 16;

  // register indexes
  localparam logic [CfgIdxW-1:0] CfgDryGain  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgWetGain  = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgFbGain   = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgLastPos  = 2'd3;

  // register reset values
  localparam logic [GainW-1:0] DryGainRst = 16'd13107;
  localparam logic [GainW-1:0] WetGainRst = 16'd19661;
  localparam logic [GainW-1:0] FbGainRst  = 16'd13107;
  localparam logic [PosW-1:0]  LastPosRst = 13'd7000;

endpackage

// File: hw/rtl/fed_ram.sv
// fed_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies
module fed_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 8192
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// File: hw/rtl/feedback_echo_delay_unit.sv
// feedback_echo_delay_unit: feedback echo on a circular delay line in block ram
// depends on fed_pkg, fed_ram and feedback_echo_delay_unit_macros.svh
//
// usage:
//   slave stream carries one signed 16-bit sample per word, master stream
//   returns one mixed, saturated 16-bit sample per accepted word, in order.
//   cfg_we_i/cfg_idx_i/cfg_wdata_i write dry, wet, feedback gain (Q1.15) and
//   the last delay position; write them only while the unit is idle.
// sequence: each accepted word passes through the read, multiply, accumulate
//   and write-back steps on the single delay ram port pair, and its result
//   enters the output register at write-back; the next word is read only
//   after the previous one has been written back.
// reset: registers take their reset values and the delay ram is zeroed by a
//   clearing pass over all 8192 entries, one entry per cycle; s_axis_tready stays low
//   during the pass (config writes are still taken).
// stall: a finished word waits in the output register; one more word is
//   accepted and processed, then its write-back waits until the output frees.
module feedback_echo_delay_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // input stream
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [15:0]                  s_axis_tdata,   // [15:0] in_sample
  // output stream
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [15:0]                  m_axis_tdata,   // [15:0] out_sample
  // configuration write port
  input  logic                         cfg_we_i,
  input  logic [fed_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [fed_pkg::CfgW-1:0]     cfg_wdata_i
);
  import fed_pkg::*;
  `include "feedback_echo_delay_unit_macros.svh"

  // sequencer states
  localparam logic [2:0] StClear = 3'd0;
  localparam logic [2:0] StIdle  = 3'd1;
  localparam logic [2:0] StMul   = 3'd2;
  localparam logic [2:0] StAcc   = 3'd3;
  localparam logic [2:0] StWb    = 3'd4;

  localparam logic signed [49:0] TruncBias = 50'sd1073741823;
  localparam logic signed [19:0] SatMax    = 20'sd32767;
  localparam logic signed [19:0] SatMin    = -20'sd32768;
  localparam logic [RamAw-1:0]   LastAddr  = RamAw'(DelayDepth - 1);

  logic [2:0]             state_q, state_d;
  logic [GainW-1:0]       dry_q, wet_q, fb_q;
  logic [PosW-1:0]        last_q;
  logic [RamAw-1:0]       pos_q, pos_d;
  logic [RamAw-1:0]       clr_q, clr_d;
  logic [31:0]            wf_q;
  logic signed [15:0]     x_q;
  logic signed [48:0]     p1_q;
  logic signed [33:0]     p2_q;
  logic signed [49:0]     acc_q;
  logic                   m_valid_q, m_valid_d;
  logic [SampleW-1:0]     m_data_q;

  logic                   in_fire, wb_fire;
  logic [16:0]            gsum;
  logic signed [49:0]     acc_t;
  logic signed [19:0]     quot;
  logic [SampleW-1:0]     y_sat;
  logic                   ram_we;
  logic [RamAw-1:0]       ram_waddr;
  logic [SampleW-1:0]     ram_wdata;
  logic [SampleW-1:0]     ram_rdata;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dry_q  <= DryGainRst;
      wet_q  <= WetGainRst;
      fb_q   <= FbGainRst;
      last_q <= LastPosRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgDryGain: dry_q  <= cfg_wdata_i;
        CfgWetGain: wet_q  <= cfg_wdata_i;
        CfgFbGain:  fb_q   <= cfg_wdata_i;
        CfgLastPos: last_q <= cfg_wdata_i[PosW-1:0];
        default: ;
      endcase
    end
  end

  // handshakes
  assign s_axis_tready = (state_q == StIdle);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign wb_fire       = (state_q == StWb) && (!m_valid_q || m_axis_tready);

  // sequencer and position control
  always_comb begin
    state_d = state_q;
    clr_d   = clr_q;
    pos_d   = pos_q;
    unique case (state_q)
      StClear: begin
        clr_d = clr_q + 1'b1;
        if (clr_q == LastAddr) begin
          state_d = StIdle;
        end
      end
      StIdle: begin
        if (in_fire) begin
          state_d = StMul;
        end
      end
      StMul: state_d = StAcc;
      StAcc: state_d = StWb;
      StWb: begin
        if (wb_fire) begin
          state_d = StIdle;
          if (32'(pos_q) >= 32'(last_q) || pos_q == LastAddr) begin
            pos_d = '0;
          end else begin
            pos_d = pos_q + 1'b1;
          end
        end
      end
      default: state_d = StClear;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StClear;
      clr_q   <= '0;
      pos_q   <= '0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      pos_q   <= pos_d;
    end
  end

  // wet times feedback gain, refreshed every cycle from the registers
  always_ff @(posedge clk_i) begin
    wf_q <= {16'b0, wet_q} * {16'b0, fb_q};
  end

  // datapath: capture, products, accumulate
  assign gsum = {1'b0, dry_q} + {1'b0, wet_q};

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      x_q <= s_axis_tdata;
    end
    if (state_q == StMul) begin
      p1_q <= 49'(signed'({1'b0, wf_q})) * 49'(signed'(ram_rdata));
      p2_q <= 34'(signed'({1'b0, gsum})) * 34'(x_q);
    end
    if (state_q == StAcc) begin
      acc_q <= 50'(p1_q) + (50'(p2_q) <<< 15);
    end
  end

  // divide by 2^30 toward zero, then saturate
  assign acc_t = acc_q + (acc_q[49] ? TruncBias : 50'sd0);
  assign quot  = 20'(acc_t >>> 30);

  always_comb begin
    if (quot > SatMax) begin
      y_sat = 16'h7fff;
    end else if (quot < SatMin) begin
      y_sat = 16'h8000;
    end else begin
      y_sat = quot[15:0];
    end
  end

  // output register
  always_comb begin
    m_valid_d = m_valid_q;
    if (wb_fire) begin
      m_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      m_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else begin
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wb_fire) begin
      m_data_q <= y_sat;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  // delay ram: clearing pass or write-back
  assign ram_we    = (state_q == StClear) || wb_fire;
  assign ram_waddr = (state_q == StClear) ? clr_q : pos_q;
  assign ram_wdata = (state_q == StClear) ? '0 : y_sat;

  fed_ram #(
    .Width (SampleW),
    .Depth (DelayDepth)
  ) u_delay_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (pos_q),
    .rdata_o (ram_rdata)
  );

  // checks
  `FED_ASSERT_IMP(a_no_accept_in_clear, state_q == StClear, !s_axis_tready, "accept during clear")
  `FED_ASSERT_NXT(a_accept_to_mul, in_fire, state_q == StMul, "accepted word not multiplied")
  `FED_ASSERT_NXT(a_wb_to_out, wb_fire, m_axis_tvalid && state_q == StIdle, "write-back lost")
  `FED_ASSERT_IMP(a_ram_we_src, ram_we, state_q == StClear || state_q == StWb, "stray ram write")

endmodule
